>>> rtl/crsc_pkg.sv
// Shared constants and the digit segment decoder of the stepper controller.
package crsc_pkg;

    localparam int STEPS_W = 10;
    localparam int TICKS_W = 16;
    localparam int DIGIT_W = 4;
    localparam int COIL_W  = 4;
    localparam int SEG_W   = 7;
    localparam int PHASE_W = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;
    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 16;

    localparam logic [STEPS_W-1:0] STEPS_RESET = 10'd525;
    localparam logic [TICKS_W-1:0] TICKS_RESET = 16'd5000;
    localparam logic [DIGIT_W-1:0] DIGIT_MAX   = 4'd9;
    localparam logic [PHASE_W-1:0] PHASE_LAST  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_STEPS_PER_REV   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_PHASE = 1'b1;

    function automatic logic [SEG_W-1:0] digit_to_segments(input logic [DIGIT_W-1:0] digit);
        logic [SEG_W-1:0] seg;
        case (digit)
            4'd0: seg = 7'h3F;
            4'd1: seg = 7'h06;
            4'd2: seg = 7'h5B;
            4'd3: seg = 7'h4F;
            4'd4: seg = 7'h66;
            4'd5: seg = 7'h6D;
            4'd6: seg = 7'h7D;
            4'd7: seg = 7'h07;
            4'd8: seg = 7'h7F;
            4'd9: seg = 7'h6F;
            default: seg = 7'h00;
        endcase
        return seg;
    endfunction

endpackage

>>> rtl/counted_revolution_stepper_control_unit.sv
// Counted-revolution stepper controller: button edges, digit, coil sequencing.
//
// One input word is one clock tick of button levels; the block returns one result word for
// each, from an output register, in the cycle after acceptance. A new word is accepted whenever
// the output register is empty or being drained in the same cycle, so the sustained rate is one
// word per cycle while m_tready is high. The digit, run counters, phase timer and coil register
// update on each accepted word in a single pass; the register port is always ready.
module counted_revolution_stepper_control_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [crsc_pkg::S_DATA_W-1:0]     s_tdata,   // [0] count_button, [1] start_button
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [3:0] coil_drive, [10:4] segment_drive, [11] is_running, [12] is_paused
    output logic [crsc_pkg::M_DATA_W-1:0]     m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [crsc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [crsc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    logic [crsc_pkg::STEPS_W-1:0] steps_reg;
    logic [crsc_pkg::TICKS_W-1:0] ticks_reg;

    logic [crsc_pkg::DIGIT_W-1:0] press_count_reg, press_count_next;
    logic [crsc_pkg::DIGIT_W-1:0] revs_left_reg, revs_left_next;
    logic [crsc_pkg::STEPS_W-1:0] step_index_reg, step_index_next;
    logic [crsc_pkg::PHASE_W-1:0] phase_index_reg, phase_index_next;
    logic [crsc_pkg::TICKS_W-1:0] phase_timer_reg, phase_timer_next;
    logic                         running_reg, running_next;
    logic                         paused_reg, paused_next;
    logic [crsc_pkg::COIL_W-1:0]  coil_reg, coil_next;
    logic [1:0]                   prev_buttons_reg;

    logic                         m_tvalid_reg;
    logic [crsc_pkg::M_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic                         s_accept;
    logic                         count_rise;
    logic                         start_rise;
    logic [crsc_pkg::TICKS_W:0]   timer_inc;
    logic [crsc_pkg::STEPS_W:0]   step_inc;
    logic [crsc_pkg::DIGIT_W-1:0] revs_dec;

    assign s_tready  = !m_tvalid_reg || m_tready;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    assign count_rise = s_tdata[0] && !prev_buttons_reg[0];
    assign start_rise = s_tdata[1] && !prev_buttons_reg[1];
    assign timer_inc  = {1'b0, phase_timer_reg} + {{crsc_pkg::TICKS_W{1'b0}}, 1'b1};
    assign step_inc   = {1'b0, step_index_reg} + {{crsc_pkg::STEPS_W{1'b0}}, 1'b1};
    assign revs_dec   = revs_left_reg - {{(crsc_pkg::DIGIT_W-1){1'b0}}, 1'b1};

    always_comb begin
        press_count_next = press_count_reg;
        revs_left_next   = revs_left_reg;
        step_index_next  = step_index_reg;
        phase_index_next = phase_index_reg;
        phase_timer_next = phase_timer_reg;
        running_next     = running_reg;
        paused_next      = paused_reg;
        coil_next        = coil_reg;
        if (!running_reg) begin
            if (start_rise) begin
                if (press_count_reg != '0) begin
                    running_next     = 1'b1;
                    paused_next      = 1'b0;
                    revs_left_next   = press_count_reg;
                    step_index_next  = '0;
                    phase_index_next = '0;
                    phase_timer_next = '0;
                    coil_next        = crsc_pkg::COIL_W'(1);
                end
            end else if (count_rise) begin
                press_count_next = (press_count_reg >= crsc_pkg::DIGIT_MAX) ? '0
                                 : press_count_reg + crsc_pkg::DIGIT_W'(1);
            end
        end else begin
            if (start_rise) begin
                paused_next = !paused_reg;
            end
            if (!paused_next) begin
                if (coil_reg == '0) begin
                    phase_index_next = '0;
                    phase_timer_next = '0;
                    coil_next        = crsc_pkg::COIL_W'(1);
                end else if (timer_inc < {1'b0, ticks_reg}) begin
                    phase_timer_next = timer_inc[crsc_pkg::TICKS_W-1:0];
                end else begin
                    phase_timer_next = '0;
                    if (phase_index_reg != crsc_pkg::PHASE_LAST) begin
                        phase_index_next = phase_index_reg + crsc_pkg::PHASE_W'(1);
                        coil_next        = crsc_pkg::COIL_W'(1) << phase_index_next;
                    end else begin
                        phase_index_next = '0;
                        if (step_inc < {1'b0, steps_reg}) begin
                            step_index_next = step_inc[crsc_pkg::STEPS_W-1:0];
                            coil_next       = crsc_pkg::COIL_W'(1);
                        end else begin
                            step_index_next = '0;
                            coil_next       = '0;
                            revs_left_next  = revs_dec;
                            if (revs_dec == '0) begin
                                running_next     = 1'b0;
                                paused_next      = 1'b0;
                                press_count_next = '0;
                            end
                        end
                    end
                end
            end
        end
        m_tdata_next = {3'b000, paused_next, running_next,
                        crsc_pkg::digit_to_segments(press_count_next), coil_next};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            steps_reg <= crsc_pkg::STEPS_RESET;
            ticks_reg <= crsc_pkg::TICKS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                crsc_pkg::REG_STEPS_PER_REV:   steps_reg <= cfg_wdata[crsc_pkg::STEPS_W-1:0];
                crsc_pkg::REG_TICKS_PER_PHASE: ticks_reg <= cfg_wdata[crsc_pkg::TICKS_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            press_count_reg  <= '0;
            revs_left_reg    <= '0;
            step_index_reg   <= '0;
            phase_index_reg  <= '0;
            phase_timer_reg  <= '0;
            running_reg      <= 1'b0;
            paused_reg       <= 1'b0;
            coil_reg         <= '0;
            prev_buttons_reg <= '0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            if (s_accept) begin
                press_count_reg  <= press_count_next;
                revs_left_reg    <= revs_left_next;
                step_index_reg   <= step_index_next;
                phase_index_reg  <= phase_index_next;
                phase_timer_reg  <= phase_timer_next;
                running_reg      <= running_next;
                paused_reg       <= paused_next;
                coil_reg         <= coil_next;
                prev_buttons_reg <= s_tdata[1:0];
                m_tvalid_reg     <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

`ifndef SYNTH
    assert property (@(posedge aclk) disable iff (!aresetn) $onehot0(coil_reg))
        else $error("coil register not one-hot");

    assert property (@(posedge aclk) disable iff (!aresetn) !running_reg |-> !paused_reg)
        else $error("paused while idle");

    assert property (@(posedge aclk) disable iff (!aresetn) !running_reg |-> coil_reg == '0)
        else $error("coils energized while idle");

    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(running_reg) |-> coil_reg == crsc_pkg::COIL_W'(1) && phase_timer_reg == '0)
        else $error("run did not start on first phase");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && !m_tready |=> m_tvalid_reg && $stable(m_tdata_reg))
        else $error("result lost while stalled");
`endif

endmodule
